// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every edge.
`define GFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds on the edge after the antecedent.
`define GFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gfq_pkg.sv
package gfq_pkg;

  // Field widths
  localparam int VALUE_W      = 16;
  localparam int GROUP_W      = 4;
  localparam int S_TDATA_W    = 24;
  localparam int S_TUSER_W    = 1;
  localparam int M_TDATA_W    = 16;
  localparam int M_TUSER_W    = 3;

  // Sizing
  localparam int DEF_CAPACITY = 64;
  localparam int NUM_GROUPS   = 16;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Contents of one queue cell
  typedef struct packed {
    logic               valid;
    logic [GROUP_W-1:0] grp;
    logic [VALUE_W-1:0] value;
  } cell_data_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic               capture;   // latch per-cell group match
    logic               ins;       // apply an enqueue
    logic               deq;       // apply a dequeue
    logic               any_match; // some cell matched the group
    logic [GROUP_W-1:0] grp;       // group to compare / insert
  } ctl_t;

  // Fold an incoming group number onto the group range
  function automatic logic [GROUP_W-1:0] grp_fold(input logic [GROUP_W-1:0] g);
    return GROUP_W'(32'(g) % NUM_GROUPS);
  endfunction

endpackage

// File: design/gfq_cell.sv
module gfq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gfq_pkg::ctl_t              ctl_i,
  input  logic [gfq_pkg::VALUE_W-1:0] new_value_i,
  input  gfq_pkg::cell_data_t        left_i,     // neighbor toward the head
  input  gfq_pkg::cell_data_t        right_i,    // neighbor toward the tail
  input  logic                       pre_i,      // some cell before this one matched
  input  logic                       pos_left_i, // left neighbor is at/after insert point
  output logic                       pre_o,
  output logic                       pos_o,
  output gfq_pkg::cell_data_t        data_o
);
  import gfq_pkg::*;

  logic               valid_q, valid_d;
  logic [GROUP_W-1:0] grp_q, grp_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               match_q;

  assign data_o = '{valid: valid_q, grp: grp_q, value: value_q};

  // Insert point chain: inside a matching run or before it stays put
  assign pre_o = pre_i | match_q;
  assign pos_o = ctl_i.any_match ? (pre_i & ~match_q) : ~valid_q;

  // Next contents
  always_comb begin
    valid_d = valid_q;
    grp_d   = grp_q;
    value_d = value_q;
    if (ctl_i.ins) begin
      if (pos_left_i) begin
        valid_d = left_i.valid;
        grp_d   = left_i.grp;
        value_d = left_i.value;
      end else if (pos_o) begin
        valid_d = 1'b1;
        grp_d   = ctl_i.grp;
        value_d = new_value_i;
      end
    end else if (ctl_i.deq) begin
      valid_d = right_i.valid;
      grp_d   = right_i.grp;
      value_d = right_i.value;
    end
  end

  // Control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.capture) begin
        match_q <= valid_q & (grp_q == ctl_i.grp);
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    grp_q   <= grp_d;
    value_q <= value_d;
  end

endmodule

// File: design/grouped_fifo_queue_top.sv
// Channel   Dir  tdata                     tuser
// s_axis    in   [15:0] value, [19:16] grp  [0] command (0 enq, 1 deq)
// m_axis    out  [15:0] out_value           [0] out_valid, [2:1] status
//
// Each transaction runs through accept (cells latch their group match) and apply
// (an enqueue shifts cells from the insert point on, a dequeue the whole row).
// The apply cycle waits while a previous result sits unread in the output register.
// One result per input transaction; a new input is taken once the apply is done.
// Reset empties the queue at once; no clearing pass.
module grouped_fifo_queue_top #(
  parameter int CAPACITY = gfq_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [gfq_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // value, group, pad
  input  logic [gfq_pkg::S_TUSER_W-1:0] s_axis_tuser_i,  // command
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [gfq_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // out_value
  output logic [gfq_pkg::M_TUSER_W-1:0] m_axis_tuser_o   // out_valid, status
);
  import gfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q;
  logic [VALUE_W-1:0] value_q;
  logic [GROUP_W-1:0] grp_q;
  logic [GROUP_W-1:0] in_grp;
  logic               in_acc;
  logic               apply;
  logic               empty, full;
  ctl_t               ctl;

  logic               out_vld_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_flag_q;
  status_e            out_status_q;

  // Cell row wiring; index 0 and CAPACITY+1 are empty boundaries
  cell_data_t           chain [CAPACITY+2];
  logic [CAPACITY:0]    pre;
  logic [CAPACITY:0]    pos;
  logic [CAPACITY-1:0]  valid_vec;

  assign in_grp          = grp_fold(s_axis_tdata_i[VALUE_W +: GROUP_W]);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign apply           = (state_q == S_EXEC) & (~out_vld_q | m_axis_tready_i);

  assign empty = ~valid_vec[0];
  assign full  = valid_vec[CAPACITY-1];

  // Broadcast controls
  always_comb begin
    ctl.capture   = in_acc;
    ctl.ins       = apply & (cmd_q == CMD_ENQ) & ~full;
    ctl.deq       = apply & (cmd_q == CMD_DEQ) & ~empty;
    ctl.any_match = pre[CAPACITY];
    ctl.grp       = (state_q == S_IDLE) ? in_grp : grp_q;
  end

  assign chain[0]          = '0;
  assign chain[CAPACITY+1] = '0;
  assign pre[0]            = 1'b0;
  assign pos[0]            = 1'b0;

  // Row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    gfq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_value_i(value_q),
      .left_i     (chain[i]),
      .right_i    (chain[i+2]),
      .pre_i      (pre[i]),
      .pos_left_i (pos[i]),
      .pre_o      (pre[i+1]),
      .pos_o      (pos[i+1]),
      .data_o     (chain[i+1])
    );
    assign valid_vec[i] = chain[i+1].valid;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: if (apply) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Captured transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_e'(s_axis_tuser_i[0]);
      value_q <= s_axis_tdata_i[VALUE_W-1:0];
      grp_q   <= in_grp;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (apply) begin
      out_value_q <= ctl.deq ? chain[1].value : '0;
      out_flag_q  <= ctl.deq;
      if ((cmd_q == CMD_ENQ) && full) begin
        out_status_q <= ST_FULL;
      end else if ((cmd_q == CMD_DEQ) && empty) begin
        out_status_q <= ST_EMPTY;
      end else begin
        out_status_q <= ST_OK;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_status_q, out_flag_q};

  // Checks
`include "assert_macros.svh"

  `GFQ_ASSERT(a_valid_prefix, (valid_vec & (valid_vec + 1'b1)) == '0, "cell valid bits have a hole")
  `GFQ_ASSERT_NEXT(a_ins_grows, ctl.ins, $countones(valid_vec) == $past($countones(valid_vec)) + 1, "enqueue did not add one entry")
  `GFQ_ASSERT_NEXT(a_deq_shrinks, ctl.deq, $countones(valid_vec) == $past($countones(valid_vec)) - 1, "dequeue did not remove one entry")
  `GFQ_ASSERT(a_flag_ok, !(out_vld_q && out_flag_q) || (out_status_q == ST_OK), "dequeued value with error status")

endmodule
